>>> rtl/psm_pkg.sv
// ----------------------------------------------------------------------------
// psm_pkg
// Shared widths, constants and types of the pulse count speed meter.
// ----------------------------------------------------------------------------
package psm_pkg;

  // field widths
  localparam int RPM_W      = 14;
  localparam int CHAR_W     = 6;
  localparam int PULSE_W    = 32;
  localparam int SET_W      = 16;
  localparam int PROD_W     = 48;
  localparam int DIVIDEND_W = 49;
  localparam int DIVISOR_W  = 32;
  localparam int DIGIT_W    = 4;
  localparam int CFG_IDX_W  = 2;

  // scale from pulses per window in ms to revolutions per minute
  localparam logic [SET_W-1:0] RPM_SCALE   = 16'd60000;
  localparam logic [RPM_W-1:0] DISPLAY_MAX = 14'd9999;

  // reciprocal of ten, exact for values up to the display maximum
  localparam int               RECIP_W     = 13;
  localparam int               RECIP_SHIFT = 16;
  localparam logic [RECIP_W-1:0] RECIP_TEN = 13'd6554;

  // ascii codes
  localparam logic [CHAR_W-1:0] CH_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CH_SPACE = 6'd32;
  localparam logic [CHAR_W-1:0] CH_DASH  = 6'd45;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 2'd2;

  typedef logic [CHAR_W-1:0]  char_t;
  typedef logic [DIGIT_W-1:0] digit_t;

  // four display characters, most significant first
  typedef struct packed {
    char_t thou;
    char_t hund;
    char_t tens;
    char_t units;
  } disp_t;

endpackage

>>> rtl/psm_div.sv
// ----------------------------------------------------------------------------
// psm_div
// Restoring divider: one shared compare and subtract, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module psm_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [psm_pkg::DIVIDEND_W-1:0]   dividend,
  input  logic [psm_pkg::DIVISOR_W-1:0]    divisor,
  output logic                             done,
  output logic [psm_pkg::DIVIDEND_W-1:0]   quotient
);
  import psm_pkg::*;

  localparam int CNT_W = $clog2(DIVIDEND_W);

  logic [DIVISOR_W-1:0]  rem_r;
  logic [DIVISOR_W-1:0]  rem_nxt;
  logic [DIVIDEND_W-1:0] quo_r;
  logic [DIVISOR_W-1:0]  dvs_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  busy_r;
  logic                  done_r;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  ge;

  // trial subtraction of the divisor from the shifted remainder
  assign trial   = {rem_r, quo_r[DIVIDEND_W-1]};
  assign ge      = trial >= {1'b0, dvs_r};
  assign diff    = trial - {1'b0, dvs_r};
  assign rem_nxt = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];

  // sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIVIDEND_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DIVIDEND_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> rtl/psm_fmt.sv
// ----------------------------------------------------------------------------
// psm_fmt
// Decimal display formatter: one digit a cycle through a reciprocal multiply.
// ----------------------------------------------------------------------------
module psm_fmt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [psm_pkg::RPM_W-1:0]    value,
  input  logic [psm_pkg::RPM_W-1:0]    limit,
  output logic                         done,
  output psm_pkg::disp_t               disp
);
  import psm_pkg::*;

  localparam int PRODUCT_W = RPM_W + RECIP_W;
  localparam int QUOT_W    = PRODUCT_W - RECIP_SHIFT;
  localparam int TEN_W     = RPM_W + 1;

  logic [RPM_W-1:0]     val_r;
  logic [1:0]           idx_r;
  logic                 busy_r;
  logic                 done_r;
  logic                 ovf_r;
  digit_t               digit_r [4];
  logic [PRODUCT_W-1:0] product;
  logic [QUOT_W-1:0]    quot;
  logic [TEN_W-1:0]     tens_part;
  logic [TEN_W-1:0]     rem_full;
  digit_t               digit;
  logic                 blank0;
  logic                 blank1;
  logic                 blank2;

  // value divided by ten, and the digit left over
  assign product   = PRODUCT_W'(val_r) * PRODUCT_W'(RECIP_TEN);
  assign quot      = product[RECIP_SHIFT +: QUOT_W];
  assign tens_part = TEN_W'({quot, 3'b000}) + TEN_W'({quot, 1'b0});
  assign rem_full  = TEN_W'(val_r) - tens_part;
  assign digit     = rem_full[DIGIT_W-1:0];

  // sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        idx_r  <= 2'd3;
      end else if (busy_r) begin
        if (idx_r == 2'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          idx_r <= idx_r - 1'b1;
        end
      end
    end
  end

  // digit store, least significant first
  always_ff @(posedge clk) begin
    if (start) begin
      val_r <= value;
      ovf_r <= (value > limit) || (value > DISPLAY_MAX);
    end else if (busy_r) begin
      val_r          <= RPM_W'(quot);
      digit_r[idx_r] <= digit;
    end
  end

  // leading zero blanking
  assign blank0 = (digit_r[0] == '0);
  assign blank1 = blank0 && (digit_r[1] == '0);
  assign blank2 = blank1 && (digit_r[2] == '0);

  always_comb begin
    if (ovf_r) begin
      disp.thou  = CH_DASH;
      disp.hund  = CH_DASH;
      disp.tens  = CH_DASH;
      disp.units = CH_DASH;
    end else begin
      disp.thou  = blank0 ? CH_SPACE : CH_ZERO + CHAR_W'(digit_r[0]);
      disp.hund  = blank1 ? CH_SPACE : CH_ZERO + CHAR_W'(digit_r[1]);
      disp.tens  = blank2 ? CH_SPACE : CH_ZERO + CHAR_W'(digit_r[2]);
      disp.units = CH_ZERO + CHAR_W'(digit_r[3]);
    end
  end

  assign done = done_r;

endmodule

>>> rtl/pulse_count_speed_meter.sv
// ----------------------------------------------------------------------------
// pulse_count_speed_meter
// Pulse count tachometer: rounded rpm, half way smoothing and a four
// character decimal display of the smoothed rpm.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in_      input      in_valid/in_ready    in_pulse_count
//  out_     output     out_valid/out_ready  out_rpm_now, out_rpm_smoothed,
//                                           out_char_thousands .. out_char_units
//  cfg_     input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  an item's time from acceptance to its result is set mostly by the divider, which
//  makes one pass through its shared compare and subtract per quotient bit
//  in_ready is high only while the sequencer is idle; one item at a time
//  the result register holds a finished item, so in_ready returns while it waits
//  cfg_ready is always high; reset is synchronous and restores the default settings
// ----------------------------------------------------------------------------
module pulse_count_speed_meter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [psm_pkg::PULSE_W-1:0]   in_pulse_count,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [psm_pkg::RPM_W-1:0]     out_rpm_now,
  output logic [psm_pkg::RPM_W-1:0]     out_rpm_smoothed,
  output psm_pkg::char_t                out_char_thousands,
  output psm_pkg::char_t                out_char_hundreds,
  output psm_pkg::char_t                out_char_tens,
  output psm_pkg::char_t                out_char_units,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [psm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [psm_pkg::SET_W-1:0]     cfg_data
);
  import psm_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_MUL    = 8'b0000_0010,
    S_LOAD   = 8'b0000_0100,
    S_DIV    = 8'b0000_1000,
    S_SMOOTH = 8'b0001_0000,
    S_FSTART = 8'b0010_0000,
    S_FMT    = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_t;

  state_t                state_r;
  state_t                state_nxt;
  logic [SET_W-1:0]      window_r;
  logic [SET_W-1:0]      ppt_r;
  logic [RPM_W-1:0]      limit_r;
  logic [PULSE_W-1:0]    pulse_r;
  logic [PROD_W-1:0]     prod_r;
  logic [DIVISOR_W-1:0]  dvsr_r;
  logic                  zero_r;
  logic [RPM_W-1:0]      now_r;
  logic [RPM_W-1:0]      held_r;
  logic [RPM_W-1:0]      held_nxt;
  logic                  out_valid_r;
  logic [RPM_W-1:0]      out_now_r;
  logic [RPM_W-1:0]      out_smooth_r;
  disp_t                 out_disp_r;
  logic                  in_acc;
  logic                  out_load;
  logic                  div_start;
  logic                  div_done;
  logic [DIVIDEND_W-1:0] dividend;
  logic [DIVIDEND_W-1:0] quotient;
  logic                  fmt_start;
  logic                  fmt_done;
  disp_t                 disp;
  logic [RPM_W-1:0]      step_up;
  logic [RPM_W-1:0]      step_dn;
  logic [RPM_W:0]        half_up;
  logic [RPM_W:0]        half_dn;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || out_ready);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= 16'd100;
      ppt_r    <= 16'd1;
      limit_r  <= DISPLAY_MAX;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WINDOW: window_r <= cfg_data;
        CFG_PULSES: ppt_r    <= cfg_data;
        CFG_LIMIT:  limit_r  <= cfg_data[RPM_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_acc) state_nxt = S_MUL;
      S_MUL:    state_nxt = S_LOAD;
      S_LOAD:   state_nxt = S_DIV;
      S_DIV:    if (div_done) state_nxt = S_SMOOTH;
      S_SMOOTH: state_nxt = S_FSTART;
      S_FSTART: state_nxt = S_FMT;
      S_FMT:    if (fmt_done) state_nxt = S_OUT;
      S_OUT:    if (out_load) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // products of the numerator and of the two settings
  always_ff @(posedge clk) begin
    if (in_acc) begin
      pulse_r <= in_pulse_count;
    end
    if (state_r == S_MUL) begin
      prod_r <= PROD_W'(pulse_r) * PROD_W'(RPM_SCALE);
      dvsr_r <= DIVISOR_W'(window_r) * DIVISOR_W'(ppt_r);
      zero_r <= (window_r == '0) || (ppt_r == '0);
    end
  end

  // rounding term added as the divider is loaded
  assign div_start = (state_r == S_LOAD);
  assign dividend  = DIVIDEND_W'(prod_r) + DIVIDEND_W'(dvsr_r >> 1);

  psm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (dvsr_r),
    .done     (div_done),
    .quotient (quotient)
  );

  // zero setting and saturation
  always_ff @(posedge clk) begin
    if ((state_r == S_DIV) && div_done) begin
      if (zero_r) begin
        now_r <= '0;
      end else if (quotient > DIVIDEND_W'(limit_r)) begin
        now_r <= limit_r;
      end else begin
        now_r <= quotient[RPM_W-1:0];
      end
    end
  end

  // half way step toward the new rpm, rounded up
  assign half_up = ((RPM_W+1)'(now_r - held_r) + 1'b1) >> 1;
  assign half_dn = ((RPM_W+1)'(held_r - now_r) + 1'b1) >> 1;
  assign step_up = held_r + half_up[RPM_W-1:0];
  assign step_dn = held_r - half_dn[RPM_W-1:0];
  assign held_nxt = (now_r > held_r) ? step_up : step_dn;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else if (state_r == S_SMOOTH) begin
      held_r <= held_nxt;
    end
  end

  assign fmt_start = (state_r == S_FSTART);

  psm_fmt u_fmt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (fmt_start),
    .value (held_r),
    .limit (limit_r),
    .done  (fmt_done),
    .disp  (disp)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_now_r    <= now_r;
      out_smooth_r <= held_r;
      out_disp_r   <= disp;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_rpm_now        = out_now_r;
  assign out_rpm_smoothed   = out_smooth_r;
  assign out_char_thousands = out_disp_r.thou;
  assign out_char_hundreds  = out_disp_r.hund;
  assign out_char_tens      = out_disp_r.tens;
  assign out_char_units     = out_disp_r.units;

`ifndef ASSERT_OFF
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_MUL))
    else $error("accepted item did not start the sequence");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside its wait state");

  a_fmt_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    fmt_done |-> (state_r == S_FMT))
    else $error("formatter finished outside its wait state");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result raised without a finished item");
`endif

endmodule

>>> test/tb_pulse_count_speed_meter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pulse_count_speed_meter
// Self-checking bench for the pulse count speed meter. A built-in predictor
// tracks the settings and the smoothed rpm, works out rpm, smoothed rpm and
// the four display characters for each accepted item, and every result is
// checked in order. Directed cases come first, then random setting phases
// with bursty input, a varying output stall pattern and one long hold-off.
// ----------------------------------------------------------------------------
module tb_pulse_count_speed_meter;
  import psm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int CYCLE_LIMIT    = 1000000;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 100;
  localparam int PHASE_COUNT    = 12;
  localparam int PHASE_ITEMS    = 160;

  typedef struct packed {
    logic [RPM_W-1:0] rpm_now;
    logic [RPM_W-1:0] rpm_smoothed;
    disp_t            chars;
  } reading_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [PULSE_W-1:0]   in_pulse_count = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [RPM_W-1:0]     out_rpm_now;
  logic [RPM_W-1:0]     out_rpm_smoothed;
  char_t                out_char_thousands;
  char_t                out_char_hundreds;
  char_t                out_char_tens;
  char_t                out_char_units;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SET_W-1:0]     cfg_data = '0;

  // predictor copy of settings and smoothed rpm
  logic [SET_W-1:0] win_ms = 16'd100;
  logic [SET_W-1:0] ppt = 16'd1;
  logic [RPM_W-1:0] rpm_ceiling = 14'd9999;
  logic [RPM_W-1:0] held_rpm = '0;

  reading_t    readings_due[$];
  int unsigned fault_count = 0;
  int unsigned cycle_count = 0;
  bit          offering = 1'b0;
  bit          gaps_on = 1'b0;
  int unsigned burst_left = 0;
  bit          holding = 1'b0;
  logic [31:0] rx_tick = '0;
  reading_t    seen, wanted;
  event        hold_off_ev;

  pulse_count_speed_meter i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_pulse_count     (in_pulse_count),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_rpm_now        (out_rpm_now),
    .out_rpm_smoothed   (out_rpm_smoothed),
    .out_char_thousands (out_char_thousands),
    .out_char_hundreds  (out_char_hundreds),
    .out_char_tens      (out_char_tens),
    .out_char_units     (out_char_units),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor

  // rounded half up, forced to zero by a zero setting, clipped at the ceiling
  function automatic logic [RPM_W-1:0] rpm_for_count(input logic [PULSE_W-1:0] count);
    logic [63:0] span;
    logic [63:0] quot;
    if (win_ms == '0 || ppt == '0) return '0;
    span = 64'(win_ms) * 64'(ppt);
    quot = (64'(count) * 64'(RPM_SCALE) + span / 2) / span;
    if (quot > 64'(rpm_ceiling)) return rpm_ceiling;
    return quot[RPM_W-1:0];
  endfunction

  // move half way, step rounded up
  function automatic logic [RPM_W-1:0] smooth_toward(input logic [RPM_W-1:0] held,
                                                     input logic [RPM_W-1:0] now);
    logic [RPM_W:0] gap;
    if (now > held) begin
      gap = now - held;
      return held + RPM_W'((gap + 1) / 2);
    end
    gap = held - now;
    return held - RPM_W'((gap + 1) / 2);
  endfunction

  // four characters, leading zeros blanked, dashes when not showable
  function automatic disp_t display_for(input logic [RPM_W-1:0] v);
    char_t       c [4];
    int unsigned rest;
    bit          blanking;
    if (v > rpm_ceiling || v > DISPLAY_MAX) return {4{CH_DASH}};
    rest = v;
    for (int i = 3; i >= 0; i--) begin
      c[i] = CH_ZERO + char_t'(rest % 10);
      rest = rest / 10;
    end
    blanking = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (c[i] != CH_ZERO) blanking = 1'b0;
      if (blanking) c[i] = CH_SPACE;
    end
    return {c[0], c[1], c[2], c[3]};
  endfunction

  function automatic reading_t predict_reading(input logic [PULSE_W-1:0] count);
    reading_t r;
    r.rpm_now      = rpm_for_count(count);
    held_rpm       = smooth_toward(held_rpm, r.rpm_now);
    r.rpm_smoothed = held_rpm;
    r.chars        = display_for(held_rpm);
    return r;
  endfunction

  function automatic string chars_text(input disp_t d);
    return $sformatf("%c%c%c%c", d.thou, d.hund, d.tens, d.units);
  endfunction

  // count picked mostly so that the rpm lands below the ceiling
  function automatic logic [PULSE_W-1:0] pick_count();
    logic [63:0] span;
    logic [63:0] top;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    span = 64'(win_ms) * 64'(ppt);
    top  = (64'(rpm_ceiling) + 1) * span / 64'(RPM_SCALE) + 1;
    if (roll < 8) return (roll < 4) ? '0 : '1;
    if (roll < 25 || span == '0) return $urandom;
    if (top > 64'hFFFF_FFFF) top = 64'hFFFF_FFFF;
    return $urandom_range(0, top[31:0]);
  endfunction

  // ---------------------------------------------------------------------------
  // drivers

  // offer one item, keep valid up while a burst runs on
  task automatic send_count(input logic [PULSE_W-1:0] count);
    in_valid       <= 1'b1;
    in_pulse_count <= count;
    offering = 1'b1;
    do @(posedge clk); while (!in_ready);
    readings_due.push_back(predict_reading(count));
    if (gaps_on) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        offering = 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        burst_left = $urandom_range(1, 8);
      end else begin
        burst_left--;
      end
    end
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
    do @(posedge clk); while (readings_due.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SET_W-1:0] data,
                           input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_WINDOW: win_ms = data;
      CFG_PULSES: ppt = data;
      CFG_LIMIT:  rpm_ceiling = data[RPM_W-1:0];
      default: ;
    endcase
    if (last) cfg_valid <= 1'b0;
  endtask

  task automatic apply_settings(input logic [SET_W-1:0] w, input logic [SET_W-1:0] p,
                                input logic [SET_W-1:0] lim);
    write_reg(CFG_WINDOW, w, 1'b0);
    write_reg(CFG_PULSES, p, 1'b0);
    write_reg(CFG_LIMIT, lim, 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // tests

  // settings straight after reset: zero, small, saturating and all-ones counts
  task automatic test_defaults();
    gaps_on = 1'b0;
    send_count('0);
    send_count(32'd1);
    send_count(32'd16);
    send_count(32'd17);
    send_count('1);
    drain();
  endtask

  // a zero window or a zero pulses per turn gives zero rpm
  task automatic test_zero_settings();
    apply_settings(16'd0, 16'd1, 16'd9999);
    send_count('1);
    send_count(32'd12345);
    drain();
    apply_settings(16'd100, 16'd0, 16'd9999);
    send_count(32'd1000);
    drain();
  endtask

  // exact halves round up, quarters round down, widest divisor
  task automatic test_rounding();
    apply_settings(16'd60000, 16'd2, 16'd9999);
    send_count(32'd1);
    send_count(32'd3);
    drain();
    apply_settings(16'd60000, 16'd4, 16'd9999);
    send_count(32'd1);
    drain();
    apply_settings(16'hFFFF, 16'hFFFF, 16'd9999);
    send_count('1);
    drain();
  endtask

  // limit lowered under the held value: dashes on the display
  task automatic test_lowered_limit();
    apply_settings(16'd100, 16'd1, 16'd9999);
    repeat (3) send_count(32'd16);
    drain();
    apply_settings(16'd100, 16'd1, 16'd500);
    send_count(32'd16);
    drain();
  endtask

  // limit above four digits, then a zero limit
  task automatic test_wide_limit();
    apply_settings(16'd1, 16'd1, 16'hFFFF);
    repeat (5) send_count('1);
    drain();
    apply_settings(16'd1, 16'd1, 16'd0);
    repeat (3) send_count(32'd1000);
    drain();
  endtask

  // a write beyond the register list must leave the settings alone
  task automatic test_spare_index();
    apply_settings(16'd100, 16'd1, 16'd9999);
    @(posedge clk);
    write_reg(CFG_SPARE, 16'h0000, 1'b1);
    send_count(32'd5);
    drain();
  endtask

  // receiver holds off while items keep coming, so the input stalls
  task automatic test_backpressure();
    gaps_on = 1'b0;
    -> hold_off_ev;
    repeat (12) send_count(pick_count());
    drain();
  endtask

  // phases of random settings, extremes first
  task automatic test_random_phases();
    logic [SET_W-1:0] w, p, lim;
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      lim = $urandom;
      lim[RPM_W-1:0] = ($urandom_range(0, 1) == 0) ? RPM_W'($urandom_range(0, 9999))
                                                   : RPM_W'($urandom);
      w = ($urandom_range(0, 3) == 0) ? SET_W'($urandom) : SET_W'($urandom_range(1, 1000));
      p = ($urandom_range(0, 1) == 0) ? SET_W'($urandom) : SET_W'($urandom_range(1, 64));
      case (ph)
        0: begin w = 16'd1; p = 16'd1; lim[RPM_W-1:0] = DISPLAY_MAX; end
        1: begin w = 16'hFFFF; p = 16'hFFFF; lim[RPM_W-1:0] = DISPLAY_MAX; end
        2: begin w = 16'd100; p = 16'd1; lim[RPM_W-1:0] = '0; end
        3: begin w = 16'd50; p = 16'd4; lim[RPM_W-1:0] = '1; end
        4: w = '0;
        5: p = '0;
        default: ;
      endcase
      write_reg(CFG_SPARE, SET_W'($urandom), 1'b0);
      apply_settings(w, p, lim);
      gaps_on = (ph % 3 != 2);
      burst_left = $urandom_range(1, 8);
      repeat (PHASE_ITEMS) send_count(pick_count());
      drain();
    end
  endtask

  // ---------------------------------------------------------------------------
  // receiver and result check

  // long hold-off, counted here
  always begin
    @(hold_off_ev);
    @(posedge clk);
    holding <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    holding <= 1'b0;
  end

  task automatic flag_fault(input string what, input reading_t want, input reading_t got);
    fault_count++;
    if (fault_count <= 10)
      $display("%s: expected rpm %0d smoothed %0d chars '%s', got rpm %0d smoothed %0d chars '%s'",
               what, want.rpm_now, want.rpm_smoothed, chars_text(want.chars),
               got.rpm_now, got.rpm_smoothed, chars_text(got.chars));
  endtask

  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        seen = {out_rpm_now, out_rpm_smoothed, out_char_thousands, out_char_hundreds,
                out_char_tens, out_char_units};
        if (readings_due.size() == 0) begin
          flag_fault("unexpected result", '0, seen);
        end else begin
          wanted = readings_due.pop_front();
          if (seen !== wanted) flag_fault("mismatch", wanted, seen);
        end
      end
      // stall pattern taken from bits 10 and 9 of the tick counter
      if (holding) begin
        out_ready <= 1'b0;
      end else begin
        case (rx_tick[10:9])
          2'd0: out_ready <= 1'b1;
          2'd1: out_ready <= 1'($urandom_range(0, 1));
          2'd2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= rx_tick[4];
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_pulse_count_speed_meter: errors");
    $finish;
  end

  // sequence
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_defaults();
    test_zero_settings();
    test_rounding();
    test_lowered_limit();
    test_wide_limit();
    test_spare_index();
    test_backpressure();
    test_random_phases();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    fault_count += readings_due.size();
    if (fault_count == 0)
      $display("tb_pulse_count_speed_meter: clean");
    else
      $display("tb_pulse_count_speed_meter: errors");
    $finish;
  end

endmodule
